@@ hdl/spectrum_band_gain_scaler_macros.svh @@
// Assertion macros for the spectrum band gain scaler top level.
`ifndef SPECTRUM_BAND_GAIN_SCALER_MACROS_SVH
`define SPECTRUM_BAND_GAIN_SCALER_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define SBGS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define SBGS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sbgs_pkg.sv @@
// Types and constants for the spectrum band gain scaler.
package sbgs_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE             = 3'd0,
      CSR_GAIN_START         = 3'd1,
      CSR_GAIN_QUARTER       = 3'd2,
      CSR_GAIN_HALF          = 3'd3,
      CSR_GAIN_THREE_QUARTER = 3'd4,
      CSR_GAIN_END           = 3'd5
   } csr_idx_type;

   localparam logic [15:0] GAIN_RESET = 16'd4096;    // 1.0 in Q4.12
   localparam logic [10:0] MAX_BINS   = 11'd1024;
   localparam logic [23:0] SAT_MAX    = 24'hFFFFFF;
   localparam logic [15:0] NORM_ONE   = 16'd256;     // 1.0 in Q8.8

   // segment bounds of the position ratio (16 fraction bits)
   localparam logic [16:0] SEG_Q1 = 17'd16384;
   localparam logic [16:0] SEG_Q2 = 17'd32768;
   localparam logic [16:0] SEG_Q3 = 17'd49152;

   // quotient bits resolved per divider stage
   localparam int DIV_STEP = 2;

   typedef struct packed {
      logic [9:0]  idx;
      logic [15:0] mag;
      logic [15:0] peak;
      logic        last;
   } bin_side_type;

   typedef struct packed {
      logic         top;     // ratio bit 16
      bin_side_type bin;
   } rat_side_type;

   typedef struct packed {
      logic [9:0] idx;
      logic       last;
      logic       sat;
   } out_side_type;

   typedef struct packed {
      logic [9:0]  idx;
      logic [23:0] mag;
      logic        last;
   } rsp_item_type;

endpackage

@@ hdl/sbgs_div_pipe.sv @@
// Pipelined restoring divider, STEP quotient bits per stage.
module sbgs_div_pipe
   import sbgs_pkg::*;
#(
   parameter int DIV_W  = 16,
   parameter int Q_W    = 24,
   parameter int STEP   = DIV_STEP,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [DIV_W-1:0]  in_rem,
   input  logic [Q_W-1:0]    in_num,
   input  logic [DIV_W-1:0]  in_dvs,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [Q_W-1:0]    out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NSTG = Q_W / STEP;

   // wrd holds the dividend bits still to come; quotient bits shift in below
   logic              vld_ff  [NSTG];
   logic [DIV_W-1:0]  rem_ff  [NSTG];
   logic [Q_W-1:0]    wrd_ff  [NSTG];
   logic [DIV_W-1:0]  dvs_ff  [NSTG];
   logic [SIDE_W-1:0] side_ff [NSTG];

   logic              vld_src  [NSTG];
   logic [DIV_W-1:0]  rem_src  [NSTG];
   logic [Q_W-1:0]    wrd_src  [NSTG];
   logic [DIV_W-1:0]  dvs_src  [NSTG];
   logic [SIDE_W-1:0] side_src [NSTG];

   logic [DIV_W-1:0]  rem_in [NSTG];
   logic [Q_W-1:0]    wrd_in [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_stg
      if (s == 0) begin : g_first
         assign vld_src[s]  = in_vld;
         assign rem_src[s]  = in_rem;
         assign wrd_src[s]  = in_num;
         assign dvs_src[s]  = in_dvs;
         assign side_src[s] = in_side;
      end else begin : g_next
         assign vld_src[s]  = vld_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign wrd_src[s]  = wrd_ff[s-1];
         assign dvs_src[s]  = dvs_ff[s-1];
         assign side_src[s] = side_ff[s-1];
      end

      always_comb begin
         logic [DIV_W:0]   sh;
         logic [DIV_W-1:0] r;
         logic [Q_W-1:0]   w;
         r = rem_src[s];
         w = wrd_src[s];
         for (int k = 0; k < STEP; k++) begin
            sh = {r, w[Q_W-1]};
            if (sh >= {1'b0, dvs_src[s]}) begin
               r = DIV_W'(sh - {1'b0, dvs_src[s]});
               w = {w[Q_W-2:0], 1'b1};
            end else begin
               r = sh[DIV_W-1:0];
               w = {w[Q_W-2:0], 1'b0};
            end
         end
         rem_in[s] = r;
         wrd_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            wrd_ff[s]  <= wrd_in[s];
            dvs_ff[s]  <= dvs_src[s];
            side_ff[s] <= side_src[s];
         end
      end
   end

   assign out_vld  = vld_ff[NSTG-1];
   assign out_quo  = wrd_ff[NSTG-1];
   assign out_side = side_ff[NSTG-1];

endmodule

@@ hdl/spectrum_band_gain_scaler.sv @@
// Spectrum band gain scaler: top level with pipeline, registers and output buffer.
//
//   channel | direction | transfer when            | carries
//   req     | in        | req_valid && req_ready   | magnitude, bin index, counts, peak
//   rsp     | out       | rsp_valid && rsp_ready   | index, scaled magnitude, last flag
//   csr     | in        | csr_we                   | register index and write data
//
// One bin per cycle enters a 27-stage pipeline while the output buffer is not
// full; each result then leaves through the two-slot output buffer.
// Most of the depth comes from the two dividers (position ratio, peak normalisation),
// each resolving two quotient bits per stage.
// Reset (synchronous) clears all valid bits, empties the output buffer, disables
// the block and loads all gains with 1.0.
// The pipeline freezes only while both output buffer slots hold results.
`include "spectrum_band_gain_scaler_macros.svh"

module spectrum_band_gain_scaler
   import sbgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [15:0]          req_magnitude,
   input  logic [9:0]           req_bin_index,
   input  logic [10:0]          req_bin_count,
   input  logic [10:0]          req_cutoff_bin,
   input  logic [15:0]          req_peak_amplitude,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [9:0]           rsp_out_index,
   output logic [23:0]          rsp_scaled_magnitude,
   output logic                 rsp_last_bin,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   // ---------------------------------------------------------------- registers
   logic        enable_ff;
   logic [15:0] gain_start_ff, gain_quarter_ff, gain_half_ff;
   logic [15:0] gain_three_quarter_ff, gain_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff             <= 1'b0;
         gain_start_ff         <= GAIN_RESET;
         gain_quarter_ff       <= GAIN_RESET;
         gain_half_ff          <= GAIN_RESET;
         gain_three_quarter_ff <= GAIN_RESET;
         gain_end_ff           <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENABLE:             enable_ff             <= csr_wdata[0];
            CSR_GAIN_START:         gain_start_ff         <= csr_wdata;
            CSR_GAIN_QUARTER:       gain_quarter_ff       <= csr_wdata;
            CSR_GAIN_HALF:          gain_half_ff          <= csr_wdata;
            CSR_GAIN_THREE_QUARTER: gain_three_quarter_ff <= csr_wdata;
            CSR_GAIN_END:           gain_end_ff           <= csr_wdata;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // ------------------------------------------------------- flow control
   // whole pipeline steps together; it only halts when the buffer is full
   logic [1:0] cnt_ff;
   logic       adv;
   logic       push, pop;

   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;

   // ---------------------------------------------- stage A: range and denominator
   logic [10:0]  count_cl, valid_cnt;
   logic         keep_in;
   logic [9:0]   dvs_a_in;
   bin_side_type side_a_in;

   always_comb begin
      count_cl = (req_bin_count > MAX_BINS) ? MAX_BINS : req_bin_count;
      if (req_cutoff_bin != 11'd0 && req_cutoff_bin < count_cl) begin
         valid_cnt = req_cutoff_bin + 11'd1;
      end else begin
         valid_cnt = count_cl;
      end
      // bins past the valid range and disabled / empty frames are dropped here
      keep_in  = enable_ff && (req_bin_count != 11'd0) && ({1'b0, req_bin_index} < valid_cnt);
      dvs_a_in = (valid_cnt > 11'd1) ? 10'(valid_cnt - 11'd1) : 10'd1;
      side_a_in.idx  = req_bin_index;
      side_a_in.mag  = req_magnitude;
      side_a_in.peak = req_peak_amplitude;
      side_a_in.last = ({1'b0, req_bin_index} == valid_cnt - 11'd1);
   end

   logic         vld_a_ff;
   logic [9:0]   dvs_a_ff;
   bin_side_type side_a_ff;

   // ---------------------------------------------- stage B: ratio top bit
   // index never exceeds the denominator, so only bit 16 of the ratio can come
   // from the index itself; the remaining 16 bits come from zeros shifted in
   logic         vld_b_ff;
   logic [9:0]   dvs_b_ff, rem_b_ff;
   rat_side_type side_b_ff;
   logic         top_b_in;

   assign top_b_in = (side_a_ff.idx == dvs_a_ff);

   // ---------------------------------------------- ratio divider
   logic         rat_vld;
   logic [15:0]  rat_quo;
   rat_side_type rat_side;

   sbgs_div_pipe #(
      .DIV_W  (10),
      .Q_W    (16),
      .STEP   (DIV_STEP),
      .SIDE_W ($bits(rat_side_type))
   ) u_rat_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (vld_b_ff),
      .in_rem   (rem_b_ff),
      .in_num   (16'd0),
      .in_dvs   (dvs_b_ff),
      .in_side  (side_b_ff),
      .out_vld  (rat_vld),
      .out_quo  (rat_quo),
      .out_side (rat_side)
   );

   // ---------------------------------------------- stage C: segment select
   logic [16:0] ratio, off;
   logic [15:0] seg_a, seg_b;
   logic [16:0] t_c_in;
   logic        neg_c_in;
   logic [15:0] dlt_c_in;

   always_comb begin
      ratio = {rat_side.top, rat_quo};
      if (ratio <= SEG_Q1) begin
         seg_a = gain_start_ff;
         seg_b = gain_quarter_ff;
         off   = ratio;
      end else if (ratio <= SEG_Q2) begin
         seg_a = gain_quarter_ff;
         seg_b = gain_half_ff;
         off   = ratio - SEG_Q1;
      end else if (ratio <= SEG_Q3) begin
         seg_a = gain_half_ff;
         seg_b = gain_three_quarter_ff;
         off   = ratio - SEG_Q2;
      end else begin
         seg_a = gain_three_quarter_ff;
         seg_b = gain_end_ff;
         off   = ratio - SEG_Q3;
      end
      t_c_in   = {off[14:0], 2'b00};
      neg_c_in = (seg_b < seg_a);
      dlt_c_in = neg_c_in ? (seg_a - seg_b) : (seg_b - seg_a);
   end

   logic         vld_c_ff, neg_c_ff;
   logic [15:0]  a_c_ff, dlt_c_ff;
   logic [16:0]  t_c_ff;
   bin_side_type side_c_ff;

   // ---------------------------------------------- stage D: slope multiply
   logic [32:0]  mul_d;
   assign mul_d = 33'(dlt_c_ff) * 33'(t_c_ff);

   logic         vld_d_ff, neg_d_ff;
   logic [15:0]  a_d_ff, step_d_ff;
   bin_side_type side_d_ff;

   // ---------------------------------------------- stage E: interpolated gain
   logic [15:0]  gain_e_in;
   assign gain_e_in = neg_d_ff ? (a_d_ff - step_d_ff) : (a_d_ff + step_d_ff);

   logic         vld_e_ff;
   logic [15:0]  gain_e_ff;
   bin_side_type side_e_ff;

   // ---------------------------------------------- stage F: gain multiply
   logic [31:0]  prod_f_in;
   logic [15:0]  dvs_f_in;
   assign prod_f_in = 32'(side_e_ff.mag) * 32'(gain_e_ff);
   assign dvs_f_in  = (side_e_ff.peak == 16'd0) ? NORM_ONE : side_e_ff.peak;

   logic         vld_f_ff;
   logic [31:0]  prod_f_ff;
   logic [15:0]  dvs_f_ff;
   out_side_type side_f_ff;

   // ---------------------------------------------- stage G: saturation check
   // quotient fits 24 bits unless the top product byte already reaches the divisor
   logic         vld_g_ff;
   logic [15:0]  rem_g_ff, dvs_g_ff;
   logic [23:0]  num_g_ff;
   out_side_type side_g_ff;
   logic         sat_g_in;

   assign sat_g_in = ({8'd0, prod_f_ff[31:24]} >= dvs_f_ff);

   // ---------------------------------------------- stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         vld_f_ff <= 1'b0;
         vld_g_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= req_valid && keep_in;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= rat_vld;
         vld_d_ff <= vld_c_ff;
         vld_e_ff <= vld_d_ff;
         vld_f_ff <= vld_e_ff;
         vld_g_ff <= vld_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dvs_a_ff  <= dvs_a_in;
         side_a_ff <= side_a_in;

         dvs_b_ff      <= dvs_a_ff;
         rem_b_ff      <= top_b_in ? 10'd0 : side_a_ff.idx;
         side_b_ff.top <= top_b_in;
         side_b_ff.bin <= side_a_ff;

         a_c_ff    <= seg_a;
         dlt_c_ff  <= dlt_c_in;
         neg_c_ff  <= neg_c_in;
         t_c_ff    <= t_c_in;
         side_c_ff <= rat_side.bin;

         a_d_ff    <= a_c_ff;
         neg_d_ff  <= neg_c_ff;
         step_d_ff <= mul_d[31:16];
         side_d_ff <= side_c_ff;

         gain_e_ff <= gain_e_in;
         side_e_ff <= side_d_ff;

         prod_f_ff      <= prod_f_in;
         dvs_f_ff       <= dvs_f_in;
         side_f_ff.idx  <= side_e_ff.idx;
         side_f_ff.last <= side_e_ff.last;
         side_f_ff.sat  <= 1'b0;

         rem_g_ff       <= {8'd0, prod_f_ff[31:24]};
         num_g_ff       <= prod_f_ff[23:0];
         dvs_g_ff       <= dvs_f_ff;
         side_g_ff.idx  <= side_f_ff.idx;
         side_g_ff.last <= side_f_ff.last;
         side_g_ff.sat  <= sat_g_in;
      end
   end

   // ---------------------------------------------- normalisation divider
   logic         quo_vld;
   logic [23:0]  quo_val;
   out_side_type quo_side;

   sbgs_div_pipe #(
      .DIV_W  (16),
      .Q_W    (24),
      .STEP   (DIV_STEP),
      .SIDE_W ($bits(out_side_type))
   ) u_norm_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (vld_g_ff),
      .in_rem   (rem_g_ff),
      .in_num   (num_g_ff),
      .in_dvs   (dvs_g_ff),
      .in_side  (side_g_ff),
      .out_vld  (quo_vld),
      .out_quo  (quo_val),
      .out_side (quo_side)
   );

   // ---------------------------------------------- output buffer (two slots)
   rsp_item_type buf_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   rsp_item_type item_in;

   always_comb begin
      item_in.idx  = quo_side.idx;
      item_in.mag  = quo_side.sat ? SAT_MAX : quo_val;
      item_in.last = quo_side.last;
   end

   assign push = adv && quo_vld;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign rsp_valid            = (cnt_ff != 2'd0);
   assign rsp_out_index        = buf_ff[rd_ptr_ff].idx;
   assign rsp_scaled_magnitude = buf_ff[rd_ptr_ff].mag;
   assign rsp_last_bin         = buf_ff[rd_ptr_ff].last;

   // ---------------------------------------------- checks
   `SBGS_ASSERT_NOW(a_push_room, clock, reset, push, cnt_ff != 2'd2, "result pushed into full buffer")
   `SBGS_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1, "buffer count not reduced by transfer")
   `SBGS_ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(vld_a_ff) && $stable(quo_vld), "pipeline moved while halted")
   `SBGS_ASSERT_NOW(a_ratio_span, clock, reset, vld_c_ff, t_c_ff <= 17'd65536, "segment offset out of range")

endmodule

@@ dv/tb_spectrum_band_gain_scaler.sv @@
// Self-checking testbench for the spectrum band gain scaler: directed table, random frames.
`timescale 1ns / 1ps

module tb_spectrum_band_gain_scaler;
   import sbgs_pkg::*;

   localparam int CLK_PERIOD    = 20;
   localparam int DRAIN_PAD     = 40;      // covers the pipeline depth plus margin
   localparam int RAND_BINS     = 700;
   localparam int PHASES        = 8;
   localparam int OFF_PHASE     = 4;       // phase run with the block disabled
   localparam int OFF_BINS      = 25;
   localparam int HOLD_CYCLES   = 300;     // long receiver stall, well past pipeline depth
   localparam int MAX_REPORTS   = 200;
   // Slowest legal run is roughly 750 transfers, each with the longest idle gap and
   // receiver stall, plus drains and the long hold. Allow many times that.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DISABLED_ROWS = 2;       // leading table rows sent before enable is set

   // One row of the directed table. Where 'typed' is set the expectation is
   // written in by hand (hit = a result is due); otherwise the predictor decides.
   typedef struct packed {
      logic [15:0] mag;
      logic [9:0]  idx;
      logic [10:0] count;
      logic [10:0] cutoff;
      logic [15:0] peak;
      logic        typed;
      logic        hit;
      logic [23:0] want_mag;
      logic        want_last;
   } bin_row_type;

   localparam bin_row_type DIR_ROWS [23] = '{
      // block still disabled after reset: nothing comes out
      '{16'h1234, 10'd0,    11'd1,    11'd0,    16'h0000, 1'b1, 1'b0, 24'd0,       1'b0},
      '{16'hFFFF, 10'd1023, 11'd1024, 11'd0,    16'h0064, 1'b1, 1'b0, 24'd0,       1'b0},
      // unit gains from here on
      '{16'h0000, 10'd0,    11'd1,    11'd0,    16'h0000, 1'b1, 1'b1, 24'd0,       1'b1},
      '{16'hFFFF, 10'd0,    11'd1,    11'd0,    16'h0000, 1'b1, 1'b1, 24'd1048560, 1'b1},
      '{16'hFFFF, 10'd5,    11'd1024, 11'd0,    16'h0001, 1'b1, 1'b1, 24'hFFFFFF,  1'b0},
      '{16'hFFFF, 10'd1023, 11'd1024, 11'd0,    16'hFFFF, 1'b1, 1'b1, 24'd4096,    1'b1},
      '{16'h0001, 10'd1,    11'd1024, 11'd0,    16'h0001, 1'b1, 1'b1, 24'd4096,    1'b0},
      // empty frame
      '{16'h1234, 10'd0,    11'd0,    11'd0,    16'h0000, 1'b1, 1'b0, 24'd0,       1'b0},
      // count above the bin limit is clamped
      '{16'h0100, 10'd1023, 11'd2047, 11'd0,    16'h0000, 1'b1, 1'b1, 24'd4096,    1'b1},
      '{16'h0100, 10'd1000, 11'd2047, 11'd1023, 16'h0000, 1'b1, 1'b1, 24'd4096,    1'b0},
      // past the valid range, with and without a cutoff
      '{16'h0100, 10'd10,   11'd10,   11'd0,    16'h0000, 1'b1, 1'b0, 24'd0,       1'b0},
      '{16'h0100, 10'd21,   11'd100,  11'd20,   16'h0000, 1'b1, 1'b0, 24'd0,       1'b0},
      '{16'h0100, 10'd20,   11'd100,  11'd20,   16'h0100, 1'b1, 1'b1, 24'd4096,    1'b1},
      // cutoff not below the count has no effect
      '{16'h0001, 10'd49,   11'd50,   11'd50,   16'h0000, 1'b1, 1'b1, 24'd16,      1'b1},
      '{16'h0001, 10'd1023, 11'd1024, 11'd1024, 16'h0000, 1'b1, 1'b1, 24'd16,      1'b1},
      // cutoff of one leaves two bins
      '{16'h0001, 10'd0,    11'd1024, 11'd1,    16'h0000, 1'b1, 1'b1, 24'd16,      1'b0},
      '{16'h0001, 10'd1,    11'd1024, 11'd1,    16'h0000, 1'b1, 1'b1, 24'd16,      1'b1},
      '{16'h0001, 10'd2,    11'd1024, 11'd1,    16'h0000, 1'b1, 1'b0, 24'd0,       1'b0},
      '{16'h8000, 10'd7,    11'd2047, 11'd2047, 16'h0000, 1'b1, 1'b1, 24'd524288,  1'b0},
      '{16'hFFFF, 10'd3,    11'd9,    11'd0,    16'hFFFF, 1'b1, 1'b1, 24'd4096,    1'b0},
      // predicted rows
      '{16'h3A7C, 10'd4,    11'd9,    11'd0,    16'h0155, 1'b0, 1'b0, 24'd0,       1'b0},
      '{16'hC5A3, 10'd517,  11'd700,  11'd600,  16'h7E01, 1'b0, 1'b0, 24'd0,       1'b0},
      '{16'h00FF, 10'd2,    11'd3,    11'd0,    16'h0000, 1'b0, 1'b0, 24'd0,       1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [15:0]          req_magnitude;
   logic [9:0]           req_bin_index;
   logic [10:0]          req_bin_count;
   logic [10:0]          req_cutoff_bin;
   logic [15:0]          req_peak_amplitude;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [9:0]           rsp_out_index;
   logic [23:0]          rsp_scaled_magnitude;
   logic                 rsp_last_bin;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;

   // shadow copy of the register file, updated as each write lands
   logic        en_shadow;
   logic [15:0] gain_pts [5];     // start, quarter, half, three-quarter, end

   rsp_item_type scaled_bins_q [$];   // expected results, oldest first
   int           fail_count  = 0;
   int           cycle_count = 0;
   bit           quiet       = 1'b0;  // no random idle gaps or stalls on either side while set
   int           rsp_hold    = 0;     // requested long receiver stall, in cycles

   spectrum_band_gain_scaler dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_magnitude        (req_magnitude),
      .req_bin_index        (req_bin_index),
      .req_bin_count        (req_bin_count),
      .req_cutoff_bin       (req_cutoff_bin),
      .req_peak_amplitude   (req_peak_amplitude),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_index        (rsp_out_index),
      .rsp_scaled_magnitude (rsp_scaled_magnitude),
      .rsp_last_bin         (rsp_last_bin),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Expected result for one bin under the current shadow registers.
   // Returns 0 when the bin produces nothing.
   function automatic bit scale_bin(input logic [15:0] mag, input logic [9:0] idx,
                                    input logic [10:0] count, input logic [10:0] cutoff,
                                    input logic [15:0] peak, output rsp_item_type res);
      logic [10:0] span;
      logic [31:0] divisor;
      logic [31:0] ratio;
      logic [63:0] frac;
      logic [15:0] g_lo, g_hi, gain;
      logic [63:0] prod, scaled;
      res = '0;
      if (!en_shadow || count == 0)
         return 1'b0;
      span = (count > MAX_BINS) ? MAX_BINS : count;
      if (cutoff != 0 && cutoff < span)
         span = cutoff + 11'd1;
      if ({1'b0, idx} >= span)
         return 1'b0;

      // position ratio, 16 fraction bits, truncated
      divisor = (span > 1) ? 32'(span - 11'd1) : 32'd1;
      ratio   = (32'(idx) << 16) / divisor;

      // pick the curve segment and the local ratio within it
      if (ratio <= 32'(SEG_Q1)) begin
         g_lo = gain_pts[0]; g_hi = gain_pts[1]; frac = 64'(ratio) * 4;
      end else if (ratio <= 32'(SEG_Q2)) begin
         g_lo = gain_pts[1]; g_hi = gain_pts[2]; frac = 64'(ratio - 32'(SEG_Q1)) * 4;
      end else if (ratio <= 32'(SEG_Q3)) begin
         g_lo = gain_pts[2]; g_hi = gain_pts[3]; frac = 64'(ratio - 32'(SEG_Q2)) * 4;
      end else begin
         g_lo = gain_pts[3]; g_hi = gain_pts[4]; frac = 64'(ratio - 32'(SEG_Q3)) * 4;
      end

      // delta truncated towards zero, so the gain stays between the two points
      if (g_hi >= g_lo)
         gain = g_lo + 16'((64'(g_hi - g_lo) * frac) >> 16);
      else
         gain = g_lo - 16'((64'(g_lo - g_hi) * frac) >> 16);

      prod   = 64'(mag) * 64'(gain);
      scaled = (peak == 0) ? (prod >> 8) : (prod / 64'(peak));
      if (scaled > 64'(SAT_MAX))
         scaled = 64'(SAT_MAX);

      res.idx  = idx;
      res.mag  = scaled[23:0];
      res.last = ({1'b0, idx} == span - 11'd1);
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // One input transfer: optional idle gap, then offer until accepted.
   task automatic send_bin(input logic [15:0] mag, input logic [9:0] idx,
                           input logic [10:0] count, input logic [10:0] cutoff,
                           input logic [15:0] peak);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_magnitude      <= mag;
      req_bin_index      <= idx;
      req_bin_count      <= count;
      req_cutoff_bin     <= cutoff;
      req_peak_amplitude <= peak;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering, let every expected result out, then wait out the
   // pipeline in case the last bins produced nothing.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (scaled_bins_q.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type which, input logic [15:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (which)
         CSR_ENABLE:             en_shadow   = data[0];
         CSR_GAIN_START:         gain_pts[0] = data;
         CSR_GAIN_QUARTER:       gain_pts[1] = data;
         CSR_GAIN_HALF:          gain_pts[2] = data;
         CSR_GAIN_THREE_QUARTER: gain_pts[3] = data;
         CSR_GAIN_END:           gain_pts[4] = data;
         default: ;
      endcase
   endtask

   // Result side: random stall after each transfer; a long hold when asked.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            stall_left = quiet ? 0 : $urandom_range(0, 5);
         if (rsp_hold > 0) begin
            stall_left = rsp_hold;
            rsp_hold   = 0;
         end
         @(negedge clock);
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // Every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (scaled_bins_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $error("unexpected result: out_index %0d, scaled_magnitude %0d",
                      rsp_out_index, rsp_scaled_magnitude);
         end else begin
            want = scaled_bins_q.pop_front();
            check_field("out_index", 32'(want.idx), 32'(rsp_out_index));
            check_field("scaled_magnitude", 32'(want.mag), 32'(rsp_scaled_magnitude));
            check_field("last_bin", 32'(want.last), 32'(rsp_last_bin));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      bin_row_type  row;
      rsp_item_type res;
      logic [15:0]  curve [5];
      logic [15:0]  mag, peak;
      logic [10:0]  count, cutoff, span;
      logic [9:0]   idx;
      int           per_phase, sent, nbins;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_magnitude      = '0;
      req_bin_index      = '0;
      req_bin_count      = '0;
      req_cutoff_bin     = '0;
      req_peak_amplitude = '0;
      csr_we             = 1'b0;
      csr_index          = CSR_ENABLE;
      csr_wdata          = '0;
      en_shadow          = 1'b0;
      foreach (gain_pts[k]) gain_pts[k] = GAIN_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed table ---
      for (int i = 0; i < $size(DIR_ROWS); i++) begin
         row = DIR_ROWS[i];
         if (i == DISABLED_ROWS) begin
            settle();
            write_csr(CSR_ENABLE, 16'd1);
         end
         send_bin(row.mag, row.idx, row.count, row.cutoff, row.peak);
         if (row.typed) begin
            if (row.hit) begin
               res.idx  = row.idx;
               res.mag  = row.want_mag;
               res.last = row.want_last;
               scaled_bins_q.push_back(res);
            end
         end else if (scale_bin(row.mag, row.idx, row.count, row.cutoff, row.peak, res)) begin
            scaled_bins_q.push_back(res);
         end
      end
      settle();

      // --- random frames, one gain curve per phase ---
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: foreach (curve[k]) curve[k] = 16'h0000;
            1: foreach (curve[k]) curve[k] = 16'hFFFF;
            2: foreach (curve[k]) curve[k] = 16'(k * 12000 + $urandom_range(0, 11999));
            3: foreach (curve[k]) curve[4 - k] = 16'(k * 12000 + $urandom_range(0, 11999));
            default: begin
               foreach (curve[k]) begin
                  case ($urandom_range(0, 7))
                     0:       curve[k] = 16'h0000;
                     1:       curve[k] = 16'hFFFF;
                     2:       curve[k] = GAIN_RESET;
                     default: curve[k] = 16'($urandom);
                  endcase
               end
            end
         endcase
         // only bit 0 of the enable write counts
         write_csr(CSR_ENABLE, (ph == OFF_PHASE) ? 16'hFFFE : 16'h0001);
         for (int k = 0; k < 5; k++)
            write_csr(csr_idx_type'(int'(CSR_GAIN_START) + k), curve[k]);

         quiet     = (ph == 1 || ph == 6);
         per_phase = (ph == OFF_PHASE) ? OFF_BINS : RAND_BINS / (PHASES - 1);

         // saturating phase: receiver holds off while bins keep coming,
         // so the output buffer fills and the input is back-pressured
         if (ph == 1) begin
            @(negedge clock);
            rsp_hold = HOLD_CYCLES;
         end

         sent = 0;
         while (sent < per_phase) begin
            case ($urandom_range(0, 3))
               0:       count = 11'($urandom_range(1, 8));
               1:       count = 11'($urandom_range(9, 64));
               2:       count = 11'($urandom_range(65, 1024));
               default: count = 11'($urandom_range(0, 2047));
            endcase
            if ($urandom_range(0, 1) == 0)
               cutoff = 11'd0;
            else if ($urandom_range(0, 3) == 0)
               cutoff = 11'($urandom_range(0, 2047));
            else
               cutoff = 11'($urandom_range(1, count));
            case ($urandom_range(0, 3))
               0:       peak = 16'h0000;
               1:       peak = 16'($urandom_range(1, 255));   // pushes towards saturation
               default: peak = 16'($urandom);
            endcase

            // valid span, only to aim the bin index
            span = (count > MAX_BINS) ? MAX_BINS : count;
            if (cutoff != 0 && cutoff < span)
               span = cutoff + 11'd1;

            nbins = $urandom_range(1, 12);
            for (int j = 0; j < nbins && sent < per_phase; j++) begin
               case ($urandom_range(0, 9))
                  0:       idx = 10'(span - 11'd1);       // last valid bin
                  1:       idx = 10'd0;
                  2:       idx = 10'($urandom);
                  3:       idx = 10'(span);               // just past the end
                  default: idx = (span == 0) ? 10'($urandom)
                                             : 10'($urandom_range(0, span - 1));
               endcase
               mag = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 255))
                                                  : 16'($urandom);
               send_bin(mag, idx, count, cutoff, peak);
               if (scale_bin(mag, idx, count, cutoff, peak, res))
                  scaled_bins_q.push_back(res);
               sent++;
            end
         end
         settle();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
